FILE: rtl/core/system_coprocessor_registers_defines.svh
// Assertion macros for the coprocessor register block.
`ifndef SYSTEM_COPROCESSOR_REGISTERS_DEFINES_SVH
`define SYSTEM_COPROCESSOR_REGISTERS_DEFINES_SVH

`ifndef SYNTHESIS
`define SCR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SCR_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SCR_ASSERT(label, prop, msg)
`define SCR_ASSERT_NEVER(label, cond, msg)
`endif

`endif

FILE: rtl/core/scr_pkg.sv
package scr_pkg;

    localparam logic [31:0] MAIN_ID    = 32'h4105_9461;
    localparam logic [31:0] CACHE_TYPE = 32'h0F0D_2112;
    localparam logic [31:0] CTRL_KEEP  = 32'h000F_F085;
    localparam logic [31:0] CTRL_FORCE = 32'h0000_0078;
    localparam logic [31:0] CTRL_RESET = 32'h0005_707D;
    localparam logic [31:0] DTCM_RESET = 32'h0300_000A;
    localparam logic [31:0] ITCM_RESET = 32'h0000_0020;
    localparam logic [31:0] BASE_MASK  = 32'hFFFF_F000;
    localparam logic [31:0] LINE_MASK  = 32'h0000_001F;
    localparam logic [31:0] LOW12_MASK = 32'h0000_0FFF;
    localparam logic [31:0] MIN_WINDOW = 32'd512;

    // largest size shift that still leaves the window inside 32 bits
    localparam logic [4:0] MAX_SIZE = 5'd22;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [1:0] ICACHE_NONE = 2'd0;
    localparam logic [1:0] ICACHE_ALL  = 2'd1;
    localparam logic [1:0] ICACHE_LINE = 2'd2;

    // register selectors {reg_n, reg_m, op_two}
    localparam logic [10:0] SEL_MAIN_ID  = {4'd0, 4'd0, 3'd0};
    localparam logic [10:0] SEL_CACHE    = {4'd0, 4'd0, 3'd1};
    localparam logic [10:0] SEL_CONTROL  = {4'd1, 4'd0, 3'd0};
    localparam logic [10:0] SEL_WFI_A    = {4'd7, 4'd0, 3'd4};
    localparam logic [10:0] SEL_WFI_B    = {4'd7, 4'd8, 3'd2};
    localparam logic [10:0] SEL_IC_ALL   = {4'd7, 4'd5, 3'd0};
    localparam logic [10:0] SEL_IC_LINE  = {4'd7, 4'd5, 3'd1};
    localparam logic [10:0] SEL_DTCM     = {4'd9, 4'd1, 3'd0};
    localparam logic [10:0] SEL_ITCM     = {4'd9, 4'd1, 3'd1};

    typedef struct packed {
        logic       wr_ctrl;
        logic       wr_dtcm;
        logic       wr_itcm;
    } scr_action_t;

    typedef struct packed {
        logic        dtcm_on;
        logic        dtcm_readable;
        logic [31:0] dtcm_base;
        logic [31:0] dtcm_limit;
        logic        itcm_on;
        logic        itcm_readable;
        logic [31:0] itcm_limit;
    } scr_map_t;

    // (512 << size) - 1, window truncated to 32 bits
    function automatic logic [31:0] window_limit(input logic [31:0] word);
        logic [4:0]  size;
        logic [31:0] win;
        size = word[5:1];
        win  = (size > MAX_SIZE) ? 32'd0 : (MIN_WINDOW << size);
        return win - 32'd1;
    endfunction

endpackage

FILE: rtl/core/scr_req_if.sv
interface scr_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [2:0]  op_one;
    logic [3:0]  reg_n;
    logic [3:0]  reg_m;
    logic [2:0]  op_two;
    logic [31:0] write_data;

    modport source (output valid, output cmd, output op_one, output reg_n, output reg_m,
                    output op_two, output write_data, input ready);
    modport sink   (input valid, input cmd, input op_one, input reg_n, input reg_m,
                    input op_two, input write_data, output ready);
endinterface

FILE: rtl/core/scr_rsp_if.sv
interface scr_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        unknown_access;
    logic        dtcm_on;
    logic        dtcm_readable;
    logic [31:0] dtcm_base;
    logic [31:0] dtcm_limit;
    logic        itcm_on;
    logic        itcm_readable;
    logic [31:0] itcm_limit;
    logic        wait_irq;
    logic [1:0]  icache_op;
    logic [31:0] line_address;

    modport source (output valid, output read_data, output unknown_access, output dtcm_on,
                    output dtcm_readable, output dtcm_base, output dtcm_limit,
                    output itcm_on, output itcm_readable, output itcm_limit,
                    output wait_irq, output icache_op, output line_address, input ready);
    modport sink   (input valid, input read_data, input unknown_access, input dtcm_on,
                    input dtcm_readable, input dtcm_base, input dtcm_limit,
                    input itcm_on, input itcm_readable, input itcm_limit,
                    input wait_irq, input icache_op, input line_address, output ready);
endinterface

FILE: rtl/core/scr_decode.sv
module scr_decode (
    input  logic                 cmd,
    input  logic [2:0]           op_one,
    input  logic [3:0]           reg_n,
    input  logic [3:0]           reg_m,
    input  logic [2:0]           op_two,
    input  logic [31:0]          write_data,
    input  logic [31:0]          control_word,
    input  logic [31:0]          dtcm_word,
    input  logic [31:0]          itcm_word,
    output scr_pkg::scr_action_t action,
    output logic [31:0]          read_data,
    output logic                 unknown_access,
    output logic                 wait_irq,
    output logic [1:0]           icache_op,
    output logic [31:0]          line_address
);
    import scr_pkg::*;

    logic [10:0] sel;

    assign sel = {reg_n, reg_m, op_two};

    always_comb
    begin
        action         = '0;
        read_data      = '0;
        unknown_access = 1'b0;
        wait_irq       = 1'b0;
        icache_op      = ICACHE_NONE;
        line_address   = '0;
        // nonzero op_one is a no-op
        if (op_one == 3'd0)
        begin
            if (cmd == CMD_READ)
            begin
                case (sel)
                    SEL_MAIN_ID: read_data = MAIN_ID;
                    SEL_CACHE:   read_data = CACHE_TYPE;
                    SEL_CONTROL: read_data = control_word;
                    SEL_DTCM:    read_data = dtcm_word;
                    SEL_ITCM:    read_data = itcm_word;
                    default:     unknown_access = 1'b1;
                endcase
            end
            else
            begin
                case (sel)
                    SEL_CONTROL: action.wr_ctrl = 1'b1;
                    SEL_WFI_A:   wait_irq = 1'b1;
                    SEL_WFI_B:   wait_irq = 1'b1;
                    SEL_IC_ALL:  icache_op = ICACHE_ALL;
                    SEL_IC_LINE:
                    begin
                        icache_op    = ICACHE_LINE;
                        line_address = write_data & ~LINE_MASK;
                    end
                    SEL_DTCM:    action.wr_dtcm = 1'b1;
                    SEL_ITCM:    action.wr_itcm = 1'b1;
                    default:     unknown_access = 1'b1;
                endcase
            end
        end
    end

endmodule

FILE: rtl/core/scr_state.sv
module scr_state (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 commit,
    input  scr_pkg::scr_action_t action,
    input  logic [31:0]          write_data,
    output logic [31:0]          control_word,
    output logic [31:0]          dtcm_word,
    output logic [31:0]          itcm_word,
    output scr_pkg::scr_map_t    tcm_map
);
    import scr_pkg::*;

    logic [31:0] control_reg, control_next;
    logic [31:0] dtcm_reg, dtcm_next;
    logic [31:0] itcm_reg, itcm_next;

    always_comb
    begin
        control_next = control_reg;
        dtcm_next    = dtcm_reg;
        itcm_next    = itcm_reg;
        if (commit)
        begin
            if (action.wr_ctrl)
                control_next = (write_data & CTRL_KEEP) | CTRL_FORCE;
            if (action.wr_dtcm)
                dtcm_next = write_data;
            // ITCM base is fixed at zero: base bits never survive a write
            if (action.wr_itcm)
                itcm_next = write_data & LOW12_MASK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg <= CTRL_RESET;
            dtcm_reg    <= DTCM_RESET;
            itcm_reg    <= ITCM_RESET;
        end
        else
        begin
            control_reg <= control_next;
            dtcm_reg    <= dtcm_next;
            itcm_reg    <= itcm_next;
        end
    end

    assign control_word = control_reg;
    assign dtcm_word    = dtcm_reg;
    assign itcm_word    = itcm_reg;

    // mapping as it stands after the access in flight
    always_comb
    begin
        tcm_map.dtcm_on       = control_next[16];
        tcm_map.dtcm_readable = control_next[16] & ~control_next[17];
        tcm_map.dtcm_base     = dtcm_next & BASE_MASK;
        tcm_map.dtcm_limit    = (dtcm_next & BASE_MASK) + window_limit(dtcm_next);
        tcm_map.itcm_on       = control_next[18];
        tcm_map.itcm_readable = control_next[18] & ~control_next[19];
        tcm_map.itcm_limit    = window_limit(itcm_next);
    end

endmodule

FILE: rtl/core/system_coprocessor_registers.sv
// System control coprocessor registers. Each request transfer is one coprocessor access
// (read or write, addressed by op_one/reg_n/reg_m/op_two); each yields exactly one response
// transfer carrying the read value, the unknown-access flag, the TCM mapping in effect after
// the access, and the wait-for-interrupt and instruction-cache invalidate requests. One access
// is accepted per cycle unless a full pipeline stalls; the request transfer is first held in
// the request register, then one decode-and-update pass writes the response register.
// Backpressure on the response side stalls the pipeline without losing accesses.
`include "system_coprocessor_registers_defines.svh"

module system_coprocessor_registers (
    input logic      clk,
    input logic      rst_n,
    scr_req_if.sink  req,
    scr_rsp_if.source rsp
);
    import scr_pkg::*;

    // request stage
    logic        in_valid_reg;
    logic        cmd_reg;
    logic [2:0]  op_one_reg;
    logic [3:0]  reg_n_reg;
    logic [3:0]  reg_m_reg;
    logic [2:0]  op_two_reg;
    logic [31:0] write_data_reg;

    // response stage
    logic        out_valid_reg;
    logic [31:0] read_data_reg;
    logic        unknown_reg;
    scr_map_t    map_reg;
    logic        wait_irq_reg;
    logic [1:0]  icache_op_reg;
    logic [31:0] line_reg;

    logic        advance;
    scr_action_t action;
    logic [31:0] control_word, dtcm_word, itcm_word;
    logic [31:0] dec_read_data, dec_line;
    logic        dec_unknown, dec_wait_irq;
    logic [1:0]  dec_icache_op;
    scr_map_t    tcm_map;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    scr_decode u_decode (
        .cmd            (cmd_reg),
        .op_one         (op_one_reg),
        .reg_n          (reg_n_reg),
        .reg_m          (reg_m_reg),
        .op_two         (op_two_reg),
        .write_data     (write_data_reg),
        .control_word   (control_word),
        .dtcm_word      (dtcm_word),
        .itcm_word      (itcm_word),
        .action         (action),
        .read_data      (dec_read_data),
        .unknown_access (dec_unknown),
        .wait_irq       (dec_wait_irq),
        .icache_op      (dec_icache_op),
        .line_address   (dec_line)
    );

    scr_state u_state (
        .clk          (clk),
        .rst_n        (rst_n),
        .commit       (advance),
        .action       (action),
        .write_data   (write_data_reg),
        .control_word (control_word),
        .dtcm_word    (dtcm_word),
        .itcm_word    (itcm_word),
        .tcm_map      (tcm_map)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                in_valid_reg <= req.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            cmd_reg        <= req.cmd;
            op_one_reg     <= req.op_one;
            reg_n_reg      <= req.reg_n;
            reg_m_reg      <= req.reg_m;
            op_two_reg     <= req.op_two;
            write_data_reg <= req.write_data;
        end
        if (advance)
        begin
            read_data_reg <= dec_read_data;
            unknown_reg   <= dec_unknown;
            map_reg       <= tcm_map;
            wait_irq_reg  <= dec_wait_irq;
            icache_op_reg <= dec_icache_op;
            line_reg      <= dec_line;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.read_data      = read_data_reg;
    assign rsp.unknown_access = unknown_reg;
    assign rsp.dtcm_on        = map_reg.dtcm_on;
    assign rsp.dtcm_readable  = map_reg.dtcm_readable;
    assign rsp.dtcm_base      = map_reg.dtcm_base;
    assign rsp.dtcm_limit     = map_reg.dtcm_limit;
    assign rsp.itcm_on        = map_reg.itcm_on;
    assign rsp.itcm_readable  = map_reg.itcm_readable;
    assign rsp.itcm_limit     = map_reg.itcm_limit;
    assign rsp.wait_irq       = wait_irq_reg;
    assign rsp.icache_op      = icache_op_reg;
    assign rsp.line_address   = line_reg;

    `SCR_ASSERT(a_advance_fills_out, advance |=> out_valid_reg, "response stage not loaded")
    `SCR_ASSERT(a_stall_only_when_full, !req.ready |-> (in_valid_reg && out_valid_reg),
        "request stalled with room in the pipeline")
    `SCR_ASSERT_NEVER(a_bad_icache_op, out_valid_reg && (icache_op_reg == 2'd3),
        "undefined icache operation")
    `SCR_ASSERT_NEVER(a_unknown_has_data, out_valid_reg && unknown_reg && (read_data_reg != '0),
        "unknown access returned data")
    `SCR_ASSERT_NEVER(a_ctrl_force_bits, control_word[6:3] != 4'hF,
        "control forced bits cleared")

endmodule
